// ----- src/pva_pkg.sv -----
`default_nettype none
package pva_pkg;

    localparam int VOICES_DEF  = 16;
    localparam int KEYS_DEF    = 128;
    localparam int QUEUE_DEPTH = 2;

    localparam int OP_W   = 2;
    localparam int NOTE_W = 8;
    localparam int VID_W  = 4;
    localparam int ACT_W  = 2;
    localparam int OVC_W  = 4;
    localparam int NV_W   = 5;

    localparam logic [NV_W-1:0] NV_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISHED = 2'd2;

    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TRIGGER = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_REJECT  = 2'd3;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_REJECT,
        CMD_FIN,
        CMD_ON,
        CMD_OFF
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [NOTE_W-1:0] note;
        logic [VID_W-1:0]  vid;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_SCAN,
        ST_NOTE,
        ST_OLD,
        ST_WRITE
    } t_state;

endpackage
`default_nettype wire

// ----- src/pva_front.sv -----
`default_nettype none
module pva_front #(
    parameter int VOICES = pva_pkg::VOICES_DEF,
    parameter int KEYS   = pva_pkg::KEYS_DEF
) (
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [pva_pkg::OP_W-1:0]  i_op,
    input  wire logic [pva_pkg::NOTE_W-1:0] i_note,
    input  wire logic [pva_pkg::VID_W-1:0] i_vid,
    output logic                           o_push,
    input  wire logic                      i_push_ready,
    output pva_pkg::t_cmd                  o_cmd
);
    import pva_pkg::*;

    logic note_ok;
    logic vid_ok;

    assign note_ok = 32'(i_note) < KEYS;
    assign vid_ok  = 32'(i_vid) < VOICES;
    assign o_ready = i_push_ready;
    assign o_push  = i_valid && i_push_ready;

    always_comb begin
        o_cmd.note = i_note;
        o_cmd.vid  = i_vid;
        case (i_op)
            OP_NOTE_ON:  o_cmd.kind = note_ok ? CMD_ON : CMD_REJECT;
            OP_NOTE_OFF: o_cmd.kind = note_ok ? CMD_OFF : CMD_NOP;
            OP_FINISHED: o_cmd.kind = vid_ok ? CMD_FIN : CMD_NOP;
            default:     o_cmd.kind = CMD_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ----- src/pva_queue.sv -----
`default_nettype none
module pva_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_push_ready,
    input  wire pva_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_pop,
    output pva_pkg::t_cmd      o_cmd
);
    import pva_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_buf [QUEUE_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_push_ready = r_count != CW'(QUEUE_DEPTH);
    assign o_valid      = r_count != '0;
    assign o_cmd        = r_buf[r_rp];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (32'(r_wp) == QUEUE_DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (32'(r_rp) == QUEUE_DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/pva_back.sv -----
`default_nettype none
module pva_back #(
    parameter int VOICES = pva_pkg::VOICES_DEF,
    parameter int KEYS   = pva_pkg::KEYS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [pva_pkg::NV_W-1:0]    i_num_voices,
    input  wire logic                        i_valid,
    output logic                             o_pop,
    input  wire pva_pkg::t_cmd               i_cmd,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [pva_pkg::ACT_W-1:0]        o_action,
    output logic [pva_pkg::OVC_W-1:0]        o_voice,
    output logic [pva_pkg::NOTE_W-1:0]       o_note,
    output logic                             o_stolen
);
    import pva_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);
    localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;

    t_state              r_state;
    t_state              n_state;
    t_cmd                r_cmd;
    t_cmd                n_cmd;
    logic [VW-1:0]       r_v, n_v;
    logic [VW-1:0]       r_cur, n_cur;
    logic [VW-1:0]       r_start, n_start;
    logic [VW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_n, n_n;
    logic                r_stolen, n_stolen;
    logic [VOICES-1:0]   r_busy, n_busy;
    logic [VOICES-1:0]   r_has, n_has;
    logic [KEYS-1:0]     r_map_valid, n_map_valid;
    logic                r_out_valid, n_out_valid;
    logic [ACT_W-1:0]    r_out_action, n_out_action;
    logic [OVC_W-1:0]    r_out_voice, n_out_voice;
    logic [NOTE_W-1:0]   r_out_note, n_out_note;
    logic                r_out_stolen, n_out_stolen;

    logic [VW-1:0]       r_map_mem [KEYS];
    logic [NOTE_W-1:0]   r_note_mem [VOICES];
    logic [VW-1:0]       r_map_q;
    logic [NOTE_W-1:0]   r_note_q;
    logic [KW-1:0]       map_ra;
    logic                map_we;
    logic [VW-1:0]       note_ra;
    logic                note_we;

    logic [CW-1:0]       act_n;
    logic [VW-1:0]       scan_start;
    logic [VW-1:0]       cur_inc;
    logic [VW-1:0]       start_inc;
    logic [KW-1:0]       note_idx;
    logic [KW-1:0]       old_idx;

    assign note_idx = r_cmd.note[KW-1:0];
    assign old_idx  = r_note_q[KW-1:0];

    always_comb begin
        if (i_num_voices == '0) begin
            act_n = CW'(1);
        end else if (32'(i_num_voices) > VOICES) begin
            act_n = CW'(VOICES);
        end else begin
            act_n = CW'(i_num_voices);
        end
    end

    assign scan_start = (CW'(r_ptr) >= act_n) ? '0 : r_ptr;
    assign cur_inc    = (CW'(r_cur) + 1'b1 == r_n) ? '0 : r_cur + 1'b1;
    assign start_inc  = (CW'(r_start) + 1'b1 == r_n) ? '0 : r_start + 1'b1;

    // note map voice field and per-voice note, single port each
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[note_idx] <= r_v;
        end
        r_map_q <= r_map_mem[map_ra];
    end

    always_ff @(posedge i_clk) begin
        if (note_we) begin
            r_note_mem[r_v] <= r_cmd.note;
        end
        r_note_q <= r_note_mem[note_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_v          = r_v;
        n_cur        = r_cur;
        n_start      = r_start;
        n_ptr        = r_ptr;
        n_cnt        = r_cnt;
        n_n          = r_n;
        n_stolen     = r_stolen;
        n_busy       = r_busy;
        n_has        = r_has;
        n_map_valid  = r_map_valid;
        n_out_valid  = r_out_valid;
        n_out_action = r_out_action;
        n_out_voice  = r_out_voice;
        n_out_note   = r_out_note;
        n_out_stolen = r_out_stolen;
        map_ra       = note_idx;
        map_we       = 1'b0;
        note_ra      = r_v;
        note_we      = 1'b0;
        o_pop        = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid && !r_out_valid) begin
                    o_pop        = 1'b1;
                    n_cmd        = i_cmd;
                    n_out_action = ACT_NONE;
                    n_out_voice  = '0;
                    n_out_note   = '0;
                    n_out_stolen = 1'b0;
                    case (i_cmd.kind)
                        CMD_REJECT: begin
                            n_out_valid  = 1'b1;
                            n_out_action = ACT_REJECT;
                        end
                        CMD_FIN: begin
                            n_busy[VW'(i_cmd.vid)] = 1'b0;
                            n_out_valid            = 1'b1;
                        end
                        CMD_ON, CMD_OFF: begin
                            map_ra  = i_cmd.note[KW-1:0];
                            n_state = ST_MAP;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_MAP: begin
                if (r_map_valid[note_idx]) begin
                    n_busy[r_map_q] = 1'b1;
                    n_out_valid     = 1'b1;
                    n_out_action    = (r_cmd.kind == CMD_OFF) ? ACT_RELEASE : ACT_TRIGGER;
                    n_out_voice     = OVC_W'(r_map_q);
                    n_out_note      = r_cmd.note;
                    n_state         = ST_IDLE;
                end else if (r_cmd.kind == CMD_OFF) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_n     = act_n;
                    n_cur   = scan_start;
                    n_start = scan_start;
                    n_cnt   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!r_busy[r_cur]) begin
                    n_v      = r_cur;
                    n_ptr    = r_cur;
                    n_stolen = 1'b0;
                    note_ra  = r_cur;
                    n_state  = ST_NOTE;
                end else if (r_cnt == r_n - 1'b1) begin
                    n_v      = start_inc;
                    n_ptr    = start_inc;
                    n_stolen = 1'b1;
                    note_ra  = start_inc;
                    n_state  = ST_NOTE;
                end else begin
                    n_cur = cur_inc;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_NOTE: begin
                if (r_has[r_v] && 32'(r_note_q) < KEYS) begin
                    map_ra  = old_idx;
                    n_state = ST_OLD;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_OLD: begin
                if (r_map_valid[old_idx] && r_map_q == r_v) begin
                    n_map_valid[old_idx] = 1'b0;
                end
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                map_we                = 1'b1;
                note_we               = 1'b1;
                n_map_valid[note_idx] = 1'b1;
                n_has[r_v]            = 1'b1;
                n_busy[r_v]           = 1'b1;
                n_out_valid           = 1'b1;
                n_out_action          = ACT_TRIGGER;
                n_out_voice           = OVC_W'(r_v);
                n_out_note            = r_cmd.note;
                n_out_stolen          = r_stolen;
                n_state               = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_busy      <= '0;
            r_has       <= '0;
            r_map_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ptr       <= n_ptr;
            r_busy      <= n_busy;
            r_has       <= n_has;
            r_map_valid <= n_map_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_v          <= n_v;
        r_cur        <= n_cur;
        r_start      <= n_start;
        r_cnt        <= n_cnt;
        r_n          <= n_n;
        r_stolen     <= n_stolen;
        r_out_action <= n_out_action;
        r_out_voice  <= n_out_voice;
        r_out_note   <= n_out_note;
        r_out_stolen <= n_out_stolen;
    end

    assign o_out_valid = r_out_valid;
    assign o_action    = r_out_action;
    assign o_voice     = r_out_voice;
    assign o_note      = r_out_note;
    assign o_stolen    = r_out_stolen;

endmodule
`default_nettype wire

// ----- src/polyphonic_voice_allocator_top.sv -----
// Polyphonic voice allocator: maps note events onto synthesizer voices.
// Input stream s_axis_*: one event per item, op in tuser, note and voice id
// in tdata. Output stream m_axis_*: exactly one result per event, action in
// tuser, voice, played note and stolen flag in tdata.
// Config channel i_cfg_*: writes num_voices (polyphony); write it while idle only,
// the block does not enforce this. o_cfg_ready is always high.
// An item enters a two-entry command queue in the accept cycle. The engine
// then handles reject, finished and unknown events straight from idle,
// note-off and retrigger through a note map read, and a new note through
// the note map read, a round-robin scan that visits voices (1 to polyphony
// of them), one per cycle, a note read, an old-entry clear when the chosen
// voice held an older note, and the write. The result is registered at the
// end of the last engine step; the engine takes no new item until it is taken.
// Reset: all voices finished, note map cleared at once through per-key valid
// bits, scan pointer zero, polyphony 16.
// When the receiver stalls the result holds in the output register, the
// engine waits, and the queue keeps taking items until it is full.
`default_nettype none
module polyphonic_voice_allocator_top #(
    parameter int VOICES = pva_pkg::VOICES_DEF,
    parameter int KEYS   = pva_pkg::KEYS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // note[7:0], voice_id[11:8], zero
    input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // voice[3:0], played_note[11:4], stolen[12], zero
    output logic [1:0]       m_axis_tuser,  // action[1:0]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [4:0]  i_cfg_data     // num_voices[4:0]
);
    import pva_pkg::*;

    logic [NV_W-1:0]   r_num_voices;
    logic              push;
    logic              push_ready;
    t_cmd              push_cmd;
    logic              q_valid;
    logic              q_pop;
    t_cmd              q_cmd;
    logic [ACT_W-1:0]  action;
    logic [OVC_W-1:0]  voice;
    logic [NOTE_W-1:0] played_note;
    logic              stolen;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_voices <= NV_RESET;
        end else if (i_cfg_valid) begin
            r_num_voices <= i_cfg_data;
        end
    end

    pva_front #(
        .VOICES (VOICES),
        .KEYS   (KEYS)
    ) u_front (
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_note       (s_axis_tdata[7:0]),
        .i_vid        (s_axis_tdata[11:8]),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_cmd        (push_cmd)
    );

    pva_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_cmd        (push_cmd),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_cmd        (q_cmd)
    );

    pva_back #(
        .VOICES (VOICES),
        .KEYS   (KEYS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_num_voices (r_num_voices),
        .i_valid      (q_valid),
        .o_pop        (q_pop),
        .i_cmd        (q_cmd),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_action     (action),
        .o_voice      (voice),
        .o_note       (played_note),
        .o_stolen     (stolen)
    );

    assign m_axis_tdata = {3'b000, stolen, played_note, voice};
    assign m_axis_tuser = action;

endmodule
`default_nettype wire
